FILE: hdl/tpt_pkg.sv
`default_nettype none
package tpt_pkg;

    localparam int VALUE_W   = 64;
    localparam int WIDTH_W   = 32;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int BYTE_W    = 8;

    // Restoring radix-2 remainder: one dividend bit per step
    localparam int DIV_STEPS = VALUE_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [WIDTH_W-1:0] INT32_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [BYTE_W-1:0]  LEAD_MASK     = 8'hC0;
    localparam logic [BYTE_W-1:0]  CONT_TAG      = 8'h80;

    localparam logic [MODE_W-1:0] MODE_INT32  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INT64  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UTF8   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BINARY = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TRUNC_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 1'b1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_word_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic                      keep;
        logic                      end_of_item;
    } out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic fix;
        logic finish;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

FILE: hdl/tpt_ctrl.sv
`default_nettype none
module tpt_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire tpt_pkg::sts_t sts,
    output tpt_pkg::cmd_t      cmd
);
    import tpt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIX  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.need_div ? ST_DIV : ST_FIN;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/tpt_dp.sv
`default_nettype none
module tpt_dp (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire tpt_pkg::in_word_t              s_word,
    input  wire logic                           cfg_we,
    input  wire logic [tpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tpt_pkg::WIDTH_W-1:0]    cfg_data,
    input  wire tpt_pkg::cmd_t                  cmd,
    output tpt_pkg::sts_t                       sts,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output tpt_pkg::out_word_t                  m_word
);
    import tpt_pkg::*;

    // configuration
    logic [WIDTH_W-1:0] width_reg;
    logic [MODE_W-1:0]  mode_reg;

    // item capture and remainder unit
    logic [VALUE_W-1:0] val_reg;
    logic               last_reg;
    logic               neg_reg;
    logic               zero_reg;
    logic [VALUE_W-1:0] mag_reg;
    logic [WIDTH_W-1:0] rem_reg;
    logic [WIDTH_W-1:0] fm_reg;
    logic [CNT_W-1:0]   cnt_reg;

    // string/binary state
    logic [WIDTH_W-1:0] allow_reg, allow_next;
    logic               start_reg, start_next;
    logic               cut_reg, cut_next;

    logic               m_valid_reg;
    out_word_t          m_word_reg, m_word_next;

    logic               big_w;
    logic [VALUE_W-1:0] op_val;
    logic [WIDTH_W:0]   rem_sh;
    logic [WIDTH_W:0]   rem_sub;
    logic [VALUE_W-1:0] int_res;
    logic [BYTE_W-1:0]  byte_in;
    logic               is_lead;
    logic               keep;

    assign big_w  = (mode_reg == MODE_INT32) && (width_reg > INT32_POS_MAX);
    assign op_val = (mode_reg == MODE_INT32)
                  ? {{(VALUE_W-32){s_word.value[31]}}, s_word.value[31:0]}
                  : s_word.value;

    assign sts.need_div = !mode_reg[1] && (width_reg != '0) && !big_w;
    assign sts.div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign sts.out_free = !m_valid_reg || m_ready;

    // one restoring step: shift in the next magnitude bit, subtract if it fits
    assign rem_sh  = {rem_reg, mag_reg[VALUE_W-1]};
    assign rem_sub = rem_sh - {1'b0, width_reg};

    always_comb begin
        int_res = val_reg - {{(VALUE_W-WIDTH_W){1'b0}}, fm_reg};
        if (zero_reg) begin
            int_res = '0;
        end else if (mode_reg == MODE_INT32) begin
            int_res = {{(VALUE_W-32){int_res[31]}}, int_res[31:0]};
        end
    end

    assign byte_in = val_reg[BYTE_W-1:0];
    assign is_lead = (mode_reg == MODE_BINARY) || ((byte_in & LEAD_MASK) != CONT_TAG);

    always_comb begin
        allow_next = start_reg ? width_reg : allow_reg;
        cut_next   = start_reg ? 1'b0 : cut_reg;
        keep       = 1'b1;
        if (cut_next) begin
            keep = 1'b0;
        end else if (is_lead) begin
            if (allow_next == '0) begin
                cut_next = 1'b1;
                keep     = 1'b0;
            end else begin
                allow_next = allow_next - WIDTH_W'(1);
            end
        end
        start_next = last_reg;
    end

    always_comb begin
        if (mode_reg[1]) begin
            m_word_next.result_value = {{(VALUE_W-BYTE_W){1'b0}}, byte_in};
            m_word_next.keep         = keep;
            m_word_next.end_of_item  = last_reg;
        end else begin
            m_word_next.result_value = int_res;
            m_word_next.keep         = 1'b1;
            m_word_next.end_of_item  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= '0;
            mode_reg  <= MODE_INT32;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TRUNC_WIDTH: width_reg <= cfg_data;
                CFG_MODE:        mode_reg  <= cfg_data[MODE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            val_reg  <= op_val;
            last_reg <= s_word.last;
            neg_reg  <= op_val[VALUE_W-1];
            mag_reg  <= op_val[VALUE_W-1] ? -op_val : op_val;
            zero_reg <= big_w;
            rem_reg  <= '0;
            fm_reg   <= '0;
            cnt_reg  <= '0;
        end else if (cmd.div_step) begin
            mag_reg <= {mag_reg[VALUE_W-2:0], 1'b0};
            rem_reg <= rem_sub[WIDTH_W] ? rem_sh[WIDTH_W-1:0] : rem_sub[WIDTH_W-1:0];
            cnt_reg <= cnt_reg + CNT_W'(1);
        end else if (cmd.fix) begin
            // floor remainder of a negative value is W - r unless r is zero
            fm_reg <= (neg_reg && (rem_reg != '0)) ? width_reg - rem_reg : rem_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allow_reg <= '0;
            start_reg <= 1'b1;
            cut_reg   <= 1'b0;
        end else if (cmd.finish && mode_reg[1]) begin
            allow_reg <= allow_next;
            start_reg <= start_next;
            cut_reg   <= cut_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_word_reg <= m_word_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule
`default_nettype wire

FILE: hdl/truncate_partition_transform.sv
// Integer word, nonzero width: the controller runs 64 remainder steps, one fix-up
//   and one output load; the next word is not taken until the output load is done.
// Zero width, int32 with width above 2^31-1, and string/binary bytes: no remainder
//   steps; the word goes from accept straight to the output load.
// A new word is taken while the previous result still waits on m_ready.
// Synchronous active-low reset clears config, byte state and handshake state.
`default_nettype none
module truncate_partition_transform (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire tpt_pkg::in_word_t              s_word,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output tpt_pkg::out_word_t                  m_word,
    input  wire logic                           cfg_we,
    input  wire logic [tpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tpt_pkg::WIDTH_W-1:0]    cfg_data
);
    import tpt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Controller: idle, remainder steps, fix-up, output load
    tpt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: config registers, capture, remainder unit, byte cut logic,
    // output register
    tpt_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_word    (s_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

    // Never load the output register over a word that is not taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_valid || m_ready))
        else $error("output word overwritten");

    // One word in flight: an accept closes the input until the result is loaded
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word accepted while busy");

    // A result shows up only from a finish
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.finish))
        else $error("result valid without finish");

    // Remainder steps never run while the input is open
    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !s_ready)
        else $error("remainder step while idle");

endmodule
`default_nettype wire

FILE: tb/tb_truncate_partition_transform.sv
`timescale 1ns / 1ps
module tb_truncate_partition_transform;
    import tpt_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SEG_WORDS   = 22;
    localparam int SEGMENTS    = 5;
    localparam int DRAIN_WAIT  = 80;

    // One row of the directed plan: a register write, or a word to send with
    // an optional hand-typed result.
    typedef struct packed {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [WIDTH_W-1:0]   data;
        in_word_t             w;
        bit                   typed;
        out_word_t            want;
    } plan_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_word_t             s_word    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_word_t            m_word;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WIDTH_W-1:0]   cfg_data  = '0;

    // Predictor copy of the registers and the byte-mode state
    logic [WIDTH_W-1:0] cut_width;
    logic [MODE_W-1:0]  cut_mode;
    logic [WIDTH_W-1:0] allow_left;
    logic               at_item_start;
    logic               cut_seen;

    out_word_t   due_out_q[$];    // truncated words not yet seen on m_word
    out_word_t   head_word;
    plan_row_t   plan_q[$];
    logic [7:0]  text_q[$];       // bytes of one string item under construction
    int          send_idle  = 35;
    int          recv_idle  = 50;
    int          error_count = 0;
    int          cycle_count = 0;

    truncate_partition_transform u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Non-negative floor remainder of a two's complement value, d nonzero
    function automatic logic [63:0] floor_rem(input logic [63:0] u, input logic [63:0] d);
        logic [63:0] r;
        if (!u[63]) return u % d;
        r = (64'd0 - u) % d;
        return (r != 64'd0) ? d - r : 64'd0;
    endfunction

    // Predict the result word for one accepted input word; advance byte state
    function automatic out_word_t truncate_word(input in_word_t w);
        out_word_t          o;
        logic [31:0]        lo;
        logic [31:0]        res32;
        logic [63:0]        rem;
        logic [BYTE_W-1:0]  b;
        logic               kept;
        o.keep        = 1'b1;
        o.end_of_item = 1'b1;
        case (cut_mode)
            MODE_INT32: begin
                lo = w.value[31:0];
                if (cut_width > INT32_POS_MAX) begin
                    res32 = 32'd0;
                end else if (cut_width == '0) begin
                    res32 = lo;
                end else begin
                    rem   = floor_rem({{32{lo[31]}}, lo}, {32'd0, cut_width});
                    res32 = lo - rem[31:0];    // wraps at 32 bits
                end
                o.result_value = {{32{res32[31]}}, res32};
            end
            MODE_INT64: begin
                if (cut_width == '0)
                    o.result_value = w.value;
                else
                    o.result_value = w.value - floor_rem(w.value, {32'd0, cut_width});
            end
            default: begin
                b = w.value[7:0];
                if (at_item_start) begin
                    allow_left    = cut_width;
                    cut_seen      = 1'b0;
                    at_item_start = 1'b0;
                end
                if (cut_seen) begin
                    kept = 1'b0;
                end else if (cut_mode == MODE_UTF8 && (b & LEAD_MASK) == CONT_TAG) begin
                    kept = 1'b1;     // continuation bytes ride along until the cut
                end else if (allow_left == '0) begin
                    cut_seen = 1'b1;
                    kept     = 1'b0;
                end else begin
                    allow_left = allow_left - 1'b1;
                    kept       = 1'b1;
                end
                if (w.last) at_item_start = 1'b1;
                o.result_value = {56'd0, b};
                o.keep         = kept;
                o.end_of_item  = w.last;
            end
        endcase
        return o;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch, cycle %0d: %s: got %h want %h", cycle_count, what, got, want);
        error_count++;
    endtask

    // Present one word; hold it until accepted, then queue its truncated result.
    // Random idle cycles go in front of the word, never between accept and hold.
    task automatic send_word(input in_word_t w, input out_word_t want);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!s_ready);
        due_out_q.push_back(want);
    endtask

    // Drop valid, wait until every result is back, then write one register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIDTH_W-1:0] data);
        s_valid <= 1'b0;
        do @(posedge aclk); while (due_out_q.size() != 0);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_TRUNC_WIDTH) cut_width = data;
        else                        cut_mode  = data[MODE_W-1:0];
    endtask

    function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [WIDTH_W-1:0] data);
        plan_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        plan_q.push_back(r);
    endfunction

    function automatic void plan_word(input logic [63:0] value, input logic last);
        plan_row_t r;
        r         = '0;
        r.w.value = value;
        r.w.last  = last;
        plan_q.push_back(r);
    endfunction

    function automatic void plan_known(input logic [63:0] value, input logic last,
                                       input logic [63:0] res);
        plan_row_t r;
        r                   = '0;
        r.w.value           = value;
        r.w.last            = last;
        r.typed             = 1'b1;
        r.want.result_value = res;
        r.want.keep         = 1'b1;
        r.want.end_of_item  = 1'b1;
        plan_q.push_back(r);
    endfunction

    function automatic logic [WIDTH_W-1:0] pick_width(input logic [MODE_W-1:0] m);
        // Byte modes mostly get short widths so that cuts actually happen
        if ((m == MODE_UTF8 || m == MODE_BINARY) && $urandom_range(3) != 0)
            return WIDTH_W'($urandom_range(6));
        case ($urandom_range(7))
            0:       return '0;
            1:       return 32'd1;
            2:       return WIDTH_W'($urandom_range(2, 8));
            3:       return WIDTH_W'($urandom_range(9, 100));
            4:       return INT32_POS_MAX;
            5:       return 32'h8000_0000;
            6:       return 32'hFFFF_FFFF;
            default: return WIDTH_W'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] pick_int_value();
        case ($urandom_range(9))
            0:       return 64'h8000_0000_0000_0000;
            1:       return 64'h7FFF_FFFF_FFFF_FFFF;
            2:       return {32'($urandom), 32'h8000_0000};
            3:       return {32'($urandom), 32'h7FFF_FFFF};
            4:       return 64'($urandom_range(200)) - 64'd100;
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    // Fill text_q with one string item: mostly valid UTF-8 code points, with
    // stray bytes mixed in now and then
    function automatic void build_text();
        int n;
        int extra;
        text_q.delete();
        n = $urandom_range(1, 6);
        repeat (n) begin
            if ($urandom_range(99) < 12) begin
                text_q.push_back(8'($urandom));
            end else begin
                extra = $urandom_range(3);
                case (extra)
                    0:       text_q.push_back({1'b0, 7'($urandom)});
                    1:       text_q.push_back({3'b110, 5'($urandom)});
                    2:       text_q.push_back({4'b1110, 4'($urandom)});
                    default: text_q.push_back({5'b11110, 3'($urandom)});
                endcase
                repeat (extra) text_q.push_back({2'b10, 6'($urandom)});
            end
        end
    endfunction

    // Receiver: stall at the current idle rate
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Compare every accepted result word against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_out_q.size() == 0) begin
                flag_mismatch("result word with nothing pending", m_word.result_value, '0);
            end else begin
                head_word = due_out_q.pop_front();
                if (m_word.result_value !== head_word.result_value)
                    flag_mismatch("result_value", m_word.result_value, head_word.result_value);
                if (m_word.keep !== head_word.keep)
                    flag_mismatch("keep", 64'(m_word.keep), 64'(head_word.keep));
                if (m_word.end_of_item !== head_word.end_of_item)
                    flag_mismatch("end_of_item", 64'(m_word.end_of_item),
                                  64'(head_word.end_of_item));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        in_word_t          w;
        plan_row_t         row;
        out_word_t         pred;
        logic [MODE_W-1:0] seg_mode;
        int                seg_count;

        // Predictor state after reset
        cut_width     = '0;
        cut_mode      = MODE_INT32;
        allow_left    = '0;
        at_item_start = 1'b1;
        cut_seen      = 1'b0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed plan. Reset state: int32, zero width, so the low half passes.
        plan_known(64'h8000_0000_1234_5678, 1'b0, 64'h0000_0000_1234_5678);
        plan_known(64'h0000_0000_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        plan_reg(CFG_TRUNC_WIDTH, 32'd10);
        plan_known(64'd13, 1'b0, 64'd10);
        plan_known(64'hFFFF_FFFF_FFFF_FFF3, 1'b0, 64'hFFFF_FFFF_FFFF_FFEC);  // -13 -> -20
        plan_word(64'h0000_0000_8000_0000, 1'b0);        // int32 minimum
        plan_reg(CFG_TRUNC_WIDTH, INT32_POS_MAX);
        plan_word(64'h0000_0000_8000_0000, 1'b1);        // 32-bit wrap
        plan_reg(CFG_TRUNC_WIDTH, 32'h8000_0000);         // above int32 range: zero
        plan_known(64'd12345, 1'b0, 64'd0);
        plan_reg(CFG_TRUNC_WIDTH, 32'hFFFF_FFFF);
        plan_known(64'hFFFF_FFFF_FFFF_FFFB, 1'b0, 64'd0);
        plan_reg(CFG_MODE, WIDTH_W'(MODE_INT64));
        plan_word(64'h8000_0000_0000_0000, 1'b0);        // 64-bit wrap
        plan_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        plan_reg(CFG_TRUNC_WIDTH, 32'd0);
        plan_known(64'h8000_0000_0000_0000, 1'b0, 64'h8000_0000_0000_0000);
        plan_reg(CFG_TRUNC_WIDTH, 32'd1);
        plan_known(64'hDEAD_BEEF_0123_4567, 1'b1, 64'hDEAD_BEEF_0123_4567);
        // String mode, two code points: a, e-acute, then cut at b
        plan_reg(CFG_MODE, WIDTH_W'(MODE_UTF8));
        plan_reg(CFG_TRUNC_WIDTH, 32'd2);
        plan_word(64'h61, 1'b0);
        plan_word(64'hC3, 1'b0);
        plan_word(64'hA9, 1'b0);
        plan_word(64'h62, 1'b0);
        plan_word(64'h63, 1'b1);
        plan_word(64'hFFFF_FFFF_FFFF_FF41, 1'b1);        // only the low byte counts
        // Zero width: a continuation byte survives, the next lead byte cuts
        plan_reg(CFG_TRUNC_WIDTH, 32'd0);
        plan_word(64'h80, 1'b0);
        plan_word(64'h78, 1'b1);
        // Binary mode
        plan_reg(CFG_MODE, WIDTH_W'(MODE_BINARY));
        plan_reg(CFG_TRUNC_WIDTH, 32'd1);
        plan_word(64'hFF, 1'b0);
        plan_word(64'h00, 1'b1);
        // Width change inside an item waits for the next item
        plan_reg(CFG_TRUNC_WIDTH, 32'd3);
        plan_word(64'h11, 1'b0);
        plan_reg(CFG_TRUNC_WIDTH, 32'd0);
        plan_word(64'h22, 1'b1);
        plan_word(64'h44, 1'b1);
        // Mode change inside an item carries the byte state over
        plan_reg(CFG_TRUNC_WIDTH, 32'd1);
        plan_word(64'h80, 1'b0);
        plan_reg(CFG_MODE, WIDTH_W'(MODE_UTF8));
        plan_word(64'h80, 1'b0);
        plan_word(64'h61, 1'b1);
        // Integer word in the middle of a string leaves the byte state alone
        plan_word(64'hE2, 1'b0);
        plan_reg(CFG_MODE, WIDTH_W'(MODE_INT32));
        plan_word(64'd5, 1'b0);
        plan_reg(CFG_MODE, WIDTH_W'(MODE_UTF8));
        plan_word(64'h41, 1'b1);

        // Walk the plan; typed rows override the prediction, all rows advance it
        foreach (plan_q[i]) begin
            row = plan_q[i];
            if (row.is_cfg) begin
                write_reg(row.idx, row.data);
            end else begin
                pred = truncate_word(row.w);
                send_word(row.w, row.typed ? row.want : pred);
            end
        end

        // Random part: three idling phases, each a run of register settings
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin send_idle = 35; recv_idle = 50; end
                1:       begin send_idle = 50; recv_idle = 35; end
                default: begin send_idle = 0;  recv_idle = 0;  end
            endcase
            repeat (SEGMENTS) begin
                seg_mode = MODE_W'($urandom_range(3));
                write_reg(CFG_TRUNC_WIDTH, pick_width(seg_mode));
                write_reg(CFG_MODE, WIDTH_W'(seg_mode));
                seg_count = 0;
                while (seg_count < SEG_WORDS) begin
                    if (seg_mode == MODE_INT32 || seg_mode == MODE_INT64) begin
                        w.value = pick_int_value();
                        w.last  = 1'($urandom_range(1));
                        send_word(w, truncate_word(w));
                        seg_count++;
                    end else begin
                        build_text();
                        foreach (text_q[k]) begin
                            // Upper bits are noise the block must drop
                            if ($urandom_range(9) == 0)
                                w.value = {32'($urandom), 24'($urandom), text_q[k]};
                            else
                                w.value = {56'd0, text_q[k]};
                            // Now and then leave the last flag off to merge two items
                            w.last = (k == text_q.size() - 1) && ($urandom_range(19) != 0);
                            send_word(w, truncate_word(w));
                        end
                        seg_count += text_q.size();
                    end
                end
            end
        end

        // Drain: drop valid, wait for every result, then watch for strays
        s_valid <= 1'b0;
        while (due_out_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
